>>> src/hc3_pkg.sv
// Shared types, constants and modulo-26 helpers for the 3x3 Hill cipher.
package hc3_pkg;

  localparam int unsigned HC_MOD    = 26;
  // floor(2^16 / 26) rounded down, so the quotient estimate never overshoots
  localparam int unsigned MOD_RECIP = 2520;

  typedef logic [4:0]      letter_t;
  typedef letter_t [2:0]   row_t;
  typedef row_t [2:0]      mat_t;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_KEY_ROW0 = 2'd0;
  localparam cfg_idx_t CFG_KEY_ROW1 = 2'd1;
  localparam cfg_idx_t CFG_KEY_ROW2 = 2'd2;

  localparam logic FUNC_ENCRYPT = 1'b0;
  localparam logic FUNC_DECRYPT = 1'b1;

  typedef struct packed {
    logic    func;
    letter_t letter_a;
    letter_t letter_b;
    letter_t letter_c;
  } in_beat_t;

  typedef struct packed {
    letter_t out_a;
    letter_t out_b;
    letter_t out_c;
    logic    not_invertible;
  } out_beat_t;

  // cofactor stage result: reduced letters and the key's adjugate
  typedef struct packed {
    logic  func;
    row_t  vec;
    mat_t  adj;
  } cof_beat_t;

  // matrix stage result: the matrix to apply and the letters
  typedef struct packed {
    row_t  vec;
    mat_t  mat;
    logic  not_inv;
  } mat_beat_t;

  // Reduce a 5-bit letter into 0..25.
  function automatic letter_t reduce5(input logic [4:0] v);
    letter_t r;
    r = (v >= 5'(HC_MOD)) ? 5'(v - 5'(HC_MOD)) : v;
    return r;
  endfunction

  // Unpack a row register, column 0 in the low bits, each entry reduced.
  function automatic row_t unpack_row(input logic [14:0] v);
    row_t r;
    r[0] = reduce5(v[4:0]);
    r[1] = reduce5(v[9:5]);
    r[2] = reduce5(v[14:10]);
    return r;
  endfunction

  // v mod 26 by reciprocal multiply and one correction.
  function automatic letter_t mod26(input logic [15:0] v);
    logic [27:0] p;
    logic [11:0] q;
    logic [15:0] t;
    logic [5:0]  r;
    p = 28'(v) * 28'(MOD_RECIP);
    q = p[27:16];
    t = v - 16'(q * 12'(HC_MOD));
    r = t[5:0];
    if (r >= 6'(HC_MOD)) r = 6'(r - 6'(HC_MOD));
    return r[4:0];
  endfunction

  // Multiplicative inverse mod 26, zero when none exists.
  function automatic letter_t inv26(input letter_t d);
    letter_t r;
    case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/hill_cipher_3x3.sv
// Hill cipher, 3x3 key mod 26: nine-stage pipeline that takes one three-letter
// block per cycle, stalling only while out_ready is held low. Key rows are
// written through the cfg port (entries above 25 are reduced as they are
// written) and apply to every beat accepted after the write; func selects
// encryption with the key or decryption with the inverse key, which is rebuilt
// per beat by the cofactor, determinant and adjugate stages. A decryption with
// a singular key returns zeros with not_invertible set. The cfg port never
// stalls.
module hill_cipher_3x3 import hc3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_idx_t    cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_beat,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_beat
);

  mat_t      key_r;
  logic      cof_valid, cof_ready, mat_valid, mat_ready;
  cof_beat_t cof_beat;
  mat_beat_t mat_beat;

  assign cfg_ready = 1'b1;

  // key rows, held reduced mod 26
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_KEY_ROW0: key_r[0] <= unpack_row(cfg_data);
        CFG_KEY_ROW1: key_r[1] <= unpack_row(cfg_data);
        CFG_KEY_ROW2: key_r[2] <= unpack_row(cfg_data);
        default: ;
      endcase
    end
  end

  hc3_cofactor u_cofactor (
    .clk      (clk),
    .rst_n    (rst_n),
    .key      (key_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_beat  (in_beat),
    .dn_valid (cof_valid),
    .dn_ready (cof_ready),
    .dn_beat  (cof_beat)
  );

  hc3_inverse u_inverse (
    .clk      (clk),
    .rst_n    (rst_n),
    .key      (key_r),
    .up_valid (cof_valid),
    .up_ready (cof_ready),
    .up_beat  (cof_beat),
    .dn_valid (mat_valid),
    .dn_ready (mat_ready),
    .dn_beat  (mat_beat)
  );

  hc3_matvec u_matvec (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mat_valid),
    .up_ready (mat_ready),
    .up_beat  (mat_beat),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_beat  (out_beat)
  );

  // a written key row 0 holds only reduced entries
  a_key_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == CFG_KEY_ROW0) |=>
      (key_r[0][0] < 5'(HC_MOD) && key_r[0][1] < 5'(HC_MOD) &&
       key_r[0][2] < 5'(HC_MOD)))
    else $error("key row 0 holds an unreduced entry");

  // a singular decryption yields an all-zero block
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.not_invertible) |->
      (out_beat.out_a == 5'd0 && out_beat.out_b == 5'd0 && out_beat.out_c == 5'd0))
    else $error("not_invertible beat carries nonzero letters");

  // with the output draining, the pipeline never throttles its input
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is being taken");

endmodule

>>> src/hc3_cofactor.sv
// Three pipeline stages that form the adjugate of the key for each beat.
module hc3_cofactor import hc3_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mat_t      key,
  input  logic      up_valid,
  output logic      up_ready,
  input  in_beat_t  up_beat,
  output logic      dn_valid,
  input  logic      dn_ready,
  output cof_beat_t dn_beat
);

  logic s1_v_r, s2_v_r, s3_v_r;
  logic s1_rdy, s2_rdy, s3_rdy;

  logic [2:0][2:0][9:0] pq_nxt, st_nxt, s1_pq_r, s1_st_r;
  mat_t                 pqm_nxt, stm_nxt, s2_pqm_r, s2_stm_r;
  mat_t                 adj_nxt, s3_adj_r;
  logic                 s1_func_r, s2_func_r, s3_func_r;
  row_t                 vec_nxt, s1_vec_r, s2_vec_r, s3_vec_r;

  // advance a stage when it is empty or its beat moves on
  assign s3_rdy   = !s3_v_r || dn_ready;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign up_ready = s1_rdy;

  // cofactor products: adj[i][j] uses rows j+1, j+2 and columns i+1, i+2
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int R1 = (j + 1) % 3;
      localparam int R2 = (j + 2) % 3;
      localparam int C1 = (i + 1) % 3;
      localparam int C2 = (i + 2) % 3;
      assign pq_nxt[i][j]  = 10'(key[R1][C1]) * 10'(key[R2][C2]);
      assign st_nxt[i][j]  = 10'(key[R1][C2]) * 10'(key[R2][C1]);
      assign pqm_nxt[i][j] = mod26(16'(s1_pq_r[i][j]));
      assign stm_nxt[i][j] = mod26(16'(s1_st_r[i][j]));
      // difference mod 26 of two reduced values
      assign adj_nxt[i][j] = (s2_pqm_r[i][j] >= s2_stm_r[i][j]) ?
                             5'(s2_pqm_r[i][j] - s2_stm_r[i][j]) :
                             5'(6'(s2_pqm_r[i][j]) + 6'(HC_MOD) - 6'(s2_stm_r[i][j]));
    end
  end

  assign vec_nxt[0] = reduce5(up_beat.letter_a);
  assign vec_nxt[1] = reduce5(up_beat.letter_b);
  assign vec_nxt[2] = reduce5(up_beat.letter_c);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= up_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_pq_r   <= pq_nxt;
      s1_st_r   <= st_nxt;
      s1_func_r <= up_beat.func;
      s1_vec_r  <= vec_nxt;
    end
    if (s2_rdy) begin
      s2_pqm_r  <= pqm_nxt;
      s2_stm_r  <= stm_nxt;
      s2_func_r <= s1_func_r;
      s2_vec_r  <= s1_vec_r;
    end
    if (s3_rdy) begin
      s3_adj_r  <= adj_nxt;
      s3_func_r <= s2_func_r;
      s3_vec_r  <= s2_vec_r;
    end
  end

  assign dn_valid     = s3_v_r;
  assign dn_beat.func = s3_func_r;
  assign dn_beat.vec  = s3_vec_r;
  assign dn_beat.adj  = s3_adj_r;

endmodule

>>> src/hc3_inverse.sv
// Four pipeline stages: determinant, its inverse, and the matrix to apply.
module hc3_inverse import hc3_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mat_t      key,
  input  logic      up_valid,
  output logic      up_ready,
  input  cof_beat_t up_beat,
  output logic      dn_valid,
  input  logic      dn_ready,
  output mat_beat_t dn_beat
);

  logic s4_v_r, s5_v_r, s6_v_r, s7_v_r;
  logic s4_rdy, s5_rdy, s6_rdy, s7_rdy;

  logic [10:0]          dsum_nxt, s4_dsum_r;
  letter_t              inv_nxt, s5_inv_r;
  logic [2:0][2:0][9:0] prod_nxt, s6_prod_r;
  mat_t                 mat_nxt, s7_mat_r;
  mat_t                 s4_adj_r, s5_adj_r;
  logic                 s4_func_r, s5_func_r, s6_func_r;
  logic                 s5_sing_r, s6_sing_r, s7_ninv_r;
  row_t                 s4_vec_r, s5_vec_r, s6_vec_r, s7_vec_r;

  assign s7_rdy   = !s7_v_r || dn_ready;
  assign s6_rdy   = !s6_v_r || s7_rdy;
  assign s5_rdy   = !s5_v_r || s6_rdy;
  assign s4_rdy   = !s4_v_r || s5_rdy;
  assign up_ready = s4_rdy;

  // expand along row 0: column 0 of the adjugate holds those cofactors
  assign dsum_nxt = 11'(10'(key[0][0]) * 10'(up_beat.adj[0][0])) +
                    11'(10'(key[0][1]) * 10'(up_beat.adj[1][0])) +
                    11'(10'(key[0][2]) * 10'(up_beat.adj[2][0]));

  assign inv_nxt = inv26(mod26(16'(s4_dsum_r)));

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      assign prod_nxt[i][j] = 10'(s5_inv_r) * 10'(s5_adj_r[i][j]);
      // encrypt applies the key itself
      assign mat_nxt[i][j]  = (s6_func_r == FUNC_DECRYPT) ?
                              mod26(16'(s6_prod_r[i][j])) : key[i][j];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else begin
      if (s4_rdy) s4_v_r <= up_valid;
      if (s5_rdy) s5_v_r <= s4_v_r;
      if (s6_rdy) s6_v_r <= s5_v_r;
      if (s7_rdy) s7_v_r <= s6_v_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s4_rdy) begin
      s4_dsum_r <= dsum_nxt;
      s4_adj_r  <= up_beat.adj;
      s4_func_r <= up_beat.func;
      s4_vec_r  <= up_beat.vec;
    end
    if (s5_rdy) begin
      s5_inv_r  <= inv_nxt;
      s5_sing_r <= (inv_nxt == 5'd0);
      s5_adj_r  <= s4_adj_r;
      s5_func_r <= s4_func_r;
      s5_vec_r  <= s4_vec_r;
    end
    if (s6_rdy) begin
      s6_prod_r <= prod_nxt;
      s6_sing_r <= s5_sing_r;
      s6_func_r <= s5_func_r;
      s6_vec_r  <= s5_vec_r;
    end
    if (s7_rdy) begin
      s7_mat_r  <= mat_nxt;
      s7_ninv_r <= (s6_func_r == FUNC_DECRYPT) && s6_sing_r;
      s7_vec_r  <= s6_vec_r;
    end
  end

  assign dn_valid        = s7_v_r;
  assign dn_beat.vec     = s7_vec_r;
  assign dn_beat.mat     = s7_mat_r;
  assign dn_beat.not_inv = s7_ninv_r;

endmodule

>>> src/hc3_matvec.sv
// Two pipeline stages: matrix-vector product and final reduction mod 26.
module hc3_matvec import hc3_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  mat_beat_t up_beat,
  output logic      dn_valid,
  input  logic      dn_ready,
  output out_beat_t dn_beat
);

  logic s8_v_r, s9_v_r;
  logic s8_rdy, s9_rdy;

  logic [2:0][10:0] acc_nxt, s8_acc_r;
  row_t             res_nxt, s9_res_r;
  logic             s8_ninv_r, s9_ninv_r;

  assign s9_rdy   = !s9_v_r || dn_ready;
  assign s8_rdy   = !s8_v_r || s9_rdy;
  assign up_ready = s8_rdy;

  for (genvar i = 0; i < 3; i++) begin : g_row
    assign acc_nxt[i] = 11'(10'(up_beat.mat[i][0]) * 10'(up_beat.vec[0])) +
                        11'(10'(up_beat.mat[i][1]) * 10'(up_beat.vec[1])) +
                        11'(10'(up_beat.mat[i][2]) * 10'(up_beat.vec[2]));
    assign res_nxt[i] = mod26(16'(s8_acc_r[i]));
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
      s9_v_r <= 1'b0;
    end else begin
      if (s8_rdy) s8_v_r <= up_valid;
      if (s9_rdy) s9_v_r <= s8_v_r;
    end
  end

  // payload; the last stage is the output register
  always_ff @(posedge clk) begin
    if (s8_rdy) begin
      s8_acc_r  <= acc_nxt;
      s8_ninv_r <= up_beat.not_inv;
    end
    if (s9_rdy) begin
      s9_res_r  <= res_nxt;
      s9_ninv_r <= s8_ninv_r;
    end
  end

  assign dn_valid               = s9_v_r;
  assign dn_beat.out_a          = s9_res_r[0];
  assign dn_beat.out_b          = s9_res_r[1];
  assign dn_beat.out_c          = s9_res_r[2];
  assign dn_beat.not_invertible = s9_ninv_r;

endmodule
